// ----- hw/rtl/fcr_pkg.sv -----
// Shared types and constants for the framed command receiver.
// Status codes, message type codes, sync bytes, CRC helper and result word type.
package fcr_pkg;

   typedef enum logic [2:0] {
      ST_INCOMPLETE  = 3'd0,
      ST_FRAME       = 3'd1,
      ST_BAD_HEADER  = 3'd2,
      ST_BAD_LENGTH  = 3'd3,
      ST_BAD_CRC     = 3'd4,
      ST_BAD_PAYLOAD = 3'd5,
      ST_TIMEOUT     = 3'd6
   } status_type;

   localparam logic [7:0] T_HELLO    = 8'h01;
   localparam logic [7:0] T_GETCAP   = 8'h02;
   localparam logic [7:0] T_GETCFG   = 8'h03;
   localparam logic [7:0] T_SETCFG   = 8'h04;
   localparam logic [7:0] T_CAPTURE  = 8'h05;
   localparam logic [7:0] T_PERIODIC = 8'h06;
   localparam logic [7:0] T_STOP     = 8'h07;
   localparam logic [7:0] T_STATUS   = 8'h08;
   localparam logic [7:0] T_RENEW    = 8'h0C;
   localparam logic [7:0] T_LOOPBACK = 8'h0E;

   localparam logic [7:0] SYNC0 = 8'h55;
   localparam logic [7:0] SYNC1 = 8'h53;
   localparam logic [7:0] SYNC2 = 8'h41;
   localparam logic [7:0] SYNC3 = 8'h43;

   localparam logic        FUNC_TIMEOUT = 1'b1;
   localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES     = 32'hFFFFFFFF;
   localparam logic [15:0] FLAG_MASK    = 16'h0007;
   localparam logic [31:0] MIN_INTERVAL = 32'd100000;
   localparam logic [31:0] LEASE_MIN    = 32'd1000;
   localparam logic [31:0] LEASE_MAX    = 32'd10000;
   localparam int          HDR_BYTES    = 16;
   localparam int          CRC_BYTES    = 4;

   typedef struct packed {
      status_type  status;
      logic [7:0]  msg_type;
      logic [2:0]  frame_flags;
      logic [31:0] sequence_number;
      logic [8:0]  payload_bytes;
      logic [4:0]  word_index;
      logic [63:0] payload_word;
      logic        last;
   } rsp_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] sync_byte(input logic [1:0] i);
      logic [7:0] s;
      unique case (i)
         2'd0: s = SYNC0;
         2'd1: s = SYNC1;
         2'd2: s = SYNC2;
         default: s = SYNC3;
      endcase
      return s;
   endfunction

endpackage

// ----- hw/rtl/fcr_req_if.sv -----
// Input channel: one received byte or a timeout event per word.
// Depends on nothing.
interface fcr_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   modport source (output valid, output func, output data_byte, input ready);
   modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// ----- hw/rtl/fcr_rsp_if.sv -----
// Result channel: status, header fields and payload words.
// Depends on nothing.
interface fcr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  msg_type;
   logic [2:0]  frame_flags;
   logic [31:0] sequence_number;
   logic [8:0]  payload_bytes;
   logic [4:0]  word_index;
   logic [63:0] payload_word;
   logic        last;
   modport source (output valid, output status, output msg_type, output frame_flags,
                   output sequence_number, output payload_bytes, output word_index,
                   output payload_word, output last, input ready);
   modport sink   (input valid, input status, input msg_type, input frame_flags,
                   input sequence_number, input payload_bytes, input word_index,
                   input payload_word, input last, output ready);
endinterface

// ----- hw/rtl/fcr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fcr_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- hw/rtl/framed_command_receiver_crc32_core.sv -----
// Framed command receiver: sync hunt, header checks, CRC-32, payload checks.
// Depends on fcr_pkg, fcr_req_if, fcr_rsp_if and fcr_ram.
//
//   channel  dir  handshake         word
//   req_if   in   valid/ready       func, data_byte
//   rsp_if   out  valid/ready       status, header fields, payload word, last
//
// One byte is taken per cycle while no replay runs and the result queue has
// room; each byte but a good frame's last makes one result in that two-entry
// queue, so input keeps flowing while a result waits. A good frame is then
// replayed from the payload RAM, one word per read; input is held until its last word is read.
// Synchronous active-high reset clears the parser; the RAM needs no clearing.
module framed_command_receiver_crc32_core #(
   parameter int MAX_PAYLOAD  = 128,
   parameter int BUFFER_BYTES = 256
) (
   input logic      clock,
   input logic      reset,
   fcr_req_if.sink  req_if,
   fcr_rsp_if.source rsp_if
);
   import fcr_pkg::*;

   localparam int WORDS = (MAX_PAYLOAD + 7) / 8;
   localparam int AW    = $clog2(WORDS);

   logic [9:0]  byte_count_ff, byte_count_in;
   logic [9:0]  exp_len_ff, exp_len_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] last4_ff, last4_in;
   logic [7:0]  ver_ff, ver_in, type_ff, type_in, flag_lo_ff, flag_lo_in;
   logic [7:0]  flag_hi_ff, flag_hi_in, b62_ff, b62_in, ids_ff, ids_in;
   logic [31:0] seq_ff, seq_in, w16_ff, w16_in, w32_ff, w32_in, w36_ff, w36_in;
   logic [31:0] w52_ff, w52_in, w68_ff, w68_in, w76_ff, w76_in;
   logic [8:0]  len_ff, len_in;
   logic [63:0] pw_ff, pw_in;
   logic        emit_ff, emit_in, pend_ff, pend_in;
   logic [5:0]  rd_idx_ff, rd_idx_in, rd_w_ff, rd_w_in, nwords_ff, nwords_in;
   rsp_type     q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]  cnt_ff, cnt_in;

   logic        accept, push, pop, wr_en, issue;
   rsp_type     push_val;
   logic [63:0] wr_data, rd_data;
   logic [9:0]  p;
   logic [7:0]  b;
   logic [31:0] hdr_len;
   logic        pl_ok;

   assign req_if.ready = !emit_ff && !pend_ff && (cnt_ff != 2'd2);
   assign accept = req_if.valid && req_if.ready;
   assign pop    = rsp_if.valid && rsp_if.ready;
   assign issue  = emit_ff && ({1'b0, cnt_ff} + {2'b0, pend_ff} < 3'd2);
   assign b      = req_if.data_byte;
   assign p      = byte_count_ff - 10'(HDR_BYTES);
   assign hdr_len = {b, last4_ff[31:8]};

   always_comb begin
      pl_ok = 1'b1;
      unique case (type_ff)
         T_HELLO:    pl_ok = !(w16_ff[7:0] > w16_ff[15:8] || w16_ff[23:16] != 8'd0 ||
                               w16_ff[31:24] != 8'd0 || w16_ff[7:0] > 8'd1 ||
                               w16_ff[15:8] < 8'd1);
         T_SETCFG:   pl_ok = (b62_ff == 8'd10);
         T_CAPTURE:  pl_ok = (w52_ff[31:8] == 24'd0) && (w52_ff[7:0] <= 8'd2);
         T_LOOPBACK: pl_ok = (w52_ff == 32'd8);
         T_PERIODIC: pl_ok = (ids_ff != 8'd0) && (w68_ff >= MIN_INTERVAL) &&
                             (w76_ff >= LEASE_MIN) && (w76_ff <= LEASE_MAX);
         T_RENEW:    pl_ok = (w32_ff != 32'd0) && (w36_ff >= LEASE_MIN) &&
                             (w36_ff <= LEASE_MAX);
         default:    pl_ok = 1'b1;
      endcase
   end

   function automatic logic len_ok(input logic [7:0] t, input logic [31:0] n);
      logic r;
      unique case (t)
         T_HELLO:                      r = (n == 32'd20);
         T_GETCAP, T_GETCFG, T_STATUS: r = (n == 32'd0);
         T_CAPTURE:                    r = (n == 32'd60);
         T_LOOPBACK:                   r = (n == 32'd56);
         T_PERIODIC:                   r = (n == 32'd80);
         T_STOP:                       r = (n == 32'd32);
         T_RENEW:                      r = (n == 32'd40);
         T_SETCFG:                     r = (n == 32'd120);
         default:                      r = 1'b1;
      endcase
      return r;
   endfunction

   always_comb begin
      byte_count_in = byte_count_ff;
      exp_len_in    = exp_len_ff;
      crc_in        = crc_ff;
      last4_in      = last4_ff;
      ver_in        = ver_ff;
      type_in       = type_ff;
      flag_lo_in    = flag_lo_ff;
      flag_hi_in    = flag_hi_ff;
      b62_in        = b62_ff;
      ids_in        = ids_ff;
      seq_in        = seq_ff;
      w16_in        = w16_ff;
      w32_in        = w32_ff;
      w36_in        = w36_ff;
      w52_in        = w52_ff;
      w68_in        = w68_ff;
      w76_in        = w76_ff;
      len_in        = len_ff;
      pw_in         = pw_ff;
      emit_in       = emit_ff;
      pend_in       = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rd_w_in       = rd_w_ff;
      nwords_in     = nwords_ff;
      wr_en         = 1'b0;
      wr_data       = pw_ff | (64'(b) << {p[2:0], 3'b000});
      push          = 1'b0;
      push_val      = '0;
      push_val.last = 1'b1;

      if (accept) begin
         push = 1'b1;
         push_val.status = ST_INCOMPLETE;
         if (req_if.func == FUNC_TIMEOUT) begin
            push_val.status = ST_TIMEOUT;
            byte_count_in = '0;
            exp_len_in    = '0;
            crc_in        = CRC_ONES;
         end else if (byte_count_ff < 10'd4 && b != sync_byte(byte_count_ff[1:0])) begin
            // restart hunt; a 0x55 counts as the first sync byte
            byte_count_in = (b == SYNC0) ? 10'd1 : 10'd0;
            exp_len_in    = '0;
            crc_in        = CRC_ONES;
         end else if (byte_count_ff >= 10'(BUFFER_BYTES)) begin
            push_val.status = ST_BAD_LENGTH;
            byte_count_in = '0;
            exp_len_in    = '0;
            crc_in        = CRC_ONES;
         end else begin
            byte_count_in = byte_count_ff + 10'd1;
            last4_in = {b, last4_ff[31:8]};
            if (byte_count_ff >= 10'd4 && (byte_count_ff < 10'(HDR_BYTES) ||
                byte_count_ff + 10'(CRC_BYTES) < exp_len_ff)) begin
               crc_in = crc_byte(crc_ff, b);
            end
            if (byte_count_ff == 10'd4)  ver_in     = b;
            if (byte_count_ff == 10'd5)  type_in    = b;
            if (byte_count_ff == 10'd6)  flag_lo_in = b;
            if (byte_count_ff == 10'd7)  flag_hi_in = b;
            if (byte_count_ff == 10'd11) seq_in     = last4_in;
            // capture the payload fields the type checks look at
            if (byte_count_ff >= 10'(HDR_BYTES)) begin
               if (p == 10'd19) w16_in = last4_in;
               if (p == 10'd35) w32_in = last4_in;
               if (p == 10'd39) w36_in = last4_in;
               if (p == 10'd55) w52_in = last4_in;
               if (p == 10'd71) w68_in = last4_in;
               if (p == 10'd79) w76_in = last4_in;
               if (p == 10'd62) b62_in = b;
               if (p >= 10'd16 && p < 10'd32) ids_in = ids_ff | b;
               if (byte_count_ff + 10'(CRC_BYTES) < exp_len_ff) begin
                  if (p[2:0] == 3'd7 || p + 10'd1 == {1'b0, len_ff}) begin
                     wr_en = 1'b1;
                     pw_in = '0;
                  end else begin
                     pw_in = wr_data;
                  end
               end
            end

            if (byte_count_in == 10'(HDR_BYTES)) begin
               ids_in = '0;
               pw_in  = '0;
               if (ver_ff != 8'd1 || ({flag_hi_ff, flag_lo_ff} & ~FLAG_MASK) != 16'd0) begin
                  push_val.status = ST_BAD_HEADER;
                  byte_count_in = '0;
                  exp_len_in    = '0;
                  crc_in        = CRC_ONES;
               end else if (hdr_len > 32'(MAX_PAYLOAD) || !len_ok(type_ff, hdr_len)) begin
                  push_val.status = ST_BAD_LENGTH;
                  byte_count_in = '0;
                  exp_len_in    = '0;
                  crc_in        = CRC_ONES;
               end else begin
                  len_in     = hdr_len[8:0];
                  exp_len_in = 10'(HDR_BYTES + CRC_BYTES) + {1'b0, hdr_len[8:0]};
               end
            end else if (exp_len_ff != 10'd0 && byte_count_in >= exp_len_ff) begin
               byte_count_in = '0;
               exp_len_in    = '0;
               crc_in        = CRC_ONES;
               if (last4_in != ~crc_ff) begin
                  push_val.status = ST_BAD_CRC;
               end else if (!pl_ok) begin
                  push_val.status = ST_BAD_PAYLOAD;
               end else begin
                  // good frame: hold input and replay the payload words
                  push      = 1'b0;
                  emit_in   = 1'b1;
                  rd_idx_in = '0;
                  nwords_in = (len_ff == 9'd0) ? 6'd1 : 6'(({1'b0, len_ff} + 10'd7) >> 3);
               end
            end
         end
      end

      if (issue) begin
         pend_in   = 1'b1;
         rd_w_in   = rd_idx_ff;
         rd_idx_in = rd_idx_ff + 6'd1;
         if (rd_idx_ff + 6'd1 == nwords_ff) emit_in = 1'b0;
      end

      if (pend_ff) begin
         push = 1'b1;
         push_val.status          = ST_FRAME;
         push_val.msg_type        = type_ff;
         push_val.frame_flags     = flag_lo_ff[2:0];
         push_val.sequence_number = seq_ff;
         push_val.payload_bytes   = len_ff;
         push_val.word_index      = rd_w_ff[4:0];
         push_val.payload_word    = (len_ff == 9'd0) ? 64'd0 : rd_data;
         push_val.last            = (rd_w_ff + 6'd1 == nwords_ff);
      end
   end

   // two-entry result queue
   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_ff;
      priority if (push && pop) begin
         if (cnt_ff == 2'd2) begin
            q0_in = q1_ff;
            q1_in = push_val;
         end else begin
            q0_in = push_val;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) q0_in = push_val;
         else q1_in = push_val;
         cnt_in = cnt_ff + 2'd1;
      end else if (pop) begin
         q0_in  = q1_ff;
         cnt_in = cnt_ff - 2'd1;
      end
   end

   fcr_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (p[AW+2:3]),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         exp_len_ff    <= '0;
         crc_ff        <= CRC_ONES;
         emit_ff       <= 1'b0;
         pend_ff       <= 1'b0;
         cnt_ff        <= '0;
         rd_idx_ff     <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         exp_len_ff    <= exp_len_in;
         crc_ff        <= crc_in;
         emit_ff       <= emit_in;
         pend_ff       <= pend_in;
         cnt_ff        <= cnt_in;
         rd_idx_ff     <= rd_idx_in;
      end
      last4_ff   <= last4_in;
      ver_ff     <= ver_in;
      type_ff    <= type_in;
      flag_lo_ff <= flag_lo_in;
      flag_hi_ff <= flag_hi_in;
      b62_ff     <= b62_in;
      ids_ff     <= ids_in;
      seq_ff     <= seq_in;
      w16_ff     <= w16_in;
      w32_ff     <= w32_in;
      w36_ff     <= w36_in;
      w52_ff     <= w52_in;
      w68_ff     <= w68_in;
      w76_ff     <= w76_in;
      len_ff     <= len_in;
      pw_ff      <= pw_in;
      rd_w_ff    <= rd_w_in;
      nwords_ff  <= nwords_in;
      q0_ff      <= q0_in;
      q1_ff      <= q1_in;
   end

   assign rsp_if.valid           = (cnt_ff != 2'd0);
   assign rsp_if.status          = q0_ff.status;
   assign rsp_if.msg_type        = q0_ff.msg_type;
   assign rsp_if.frame_flags     = q0_ff.frame_flags;
   assign rsp_if.sequence_number = q0_ff.sequence_number;
   assign rsp_if.payload_bytes   = q0_ff.payload_bytes;
   assign rsp_if.word_index      = q0_ff.word_index;
   assign rsp_if.payload_word    = q0_ff.payload_word;
   assign rsp_if.last            = q0_ff.last;
endmodule

// ----- tb/tb_framed_command_receiver_crc32_core.sv -----
// Self-checking bench for the framed command receiver: sync hunt, header,
// length, CRC-32 and payload checks. Depends on fcr_pkg, fcr_req_if, fcr_rsp_if
// and the core; results are compared with a frame parser model kept in here.
module tb_framed_command_receiver_crc32_core;
   import fcr_pkg::*;

   localparam int MAX_PAYLOAD  = 128;
   localparam int BUFFER_BYTES = 256;
   localparam int ITEMS        = 400;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int DIR_ROWS     = 25;

   typedef struct packed {
      logic       f;
      logic [7:0] b;
      logic       typed;
      status_type s;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fcr_req_if req_if ();
   fcr_rsp_if rsp_if ();

   framed_command_receiver_crc32_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .BUFFER_BYTES(BUFFER_BYTES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   always #10 clock = ~clock;

   // parser model state
   logic [7:0]  rx_store [BUFFER_BYTES];
   int unsigned rx_count;
   int unsigned rx_frame_len;
   logic [31:0] rx_crc;
   rsp_type     expected_q [$];
   logic [7:0]  sync_seq [4] = '{SYNC0, SYNC1, SYNC2, SYNC3};

   int errors      = 0;
   int items_sent  = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;
   int cycles      = 0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{1'b1, 8'h00, 1'b1, ST_TIMEOUT},
      '{1'b0, 8'h00, 1'b1, ST_INCOMPLETE},
      '{1'b0, 8'hFF, 1'b1, ST_INCOMPLETE},
      '{1'b0, 8'h55, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h55, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h53, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h41, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h43, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h02, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h01, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'hFF, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h00, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h00, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'hFF, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h00, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'hFF, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h14, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h00, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h00, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h00, 1'b1, ST_BAD_HEADER},
      '{1'b0, 8'h55, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h53, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h41, 1'b0, ST_INCOMPLETE},
      '{1'b0, 8'h43, 1'b0, ST_INCOMPLETE},
      '{1'b1, 8'hFF, 1'b1, ST_TIMEOUT}
   };

   function automatic logic [31:0] crc_update(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         if (c[0] ^ b[k]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic logic [7:0] st(int unsigned i);
      return (i < BUFFER_BYTES) ? rx_store[i] : 8'h00;
   endfunction

   function automatic logic [31:0] st32(int unsigned i);
      return {st(i + 3), st(i + 2), st(i + 1), st(i)};
   endfunction

   function automatic int known_length(logic [7:0] t);
      case (t)
         T_HELLO:                     return 20;
         T_GETCAP, T_GETCFG, T_STATUS: return 0;
         T_CAPTURE:                   return 60;
         T_LOOPBACK:                  return 56;
         T_PERIODIC:                  return 80;
         T_STOP:                      return 32;
         T_RENEW:                     return 40;
         T_SETCFG:                    return 120;
         default:                     return -1;
      endcase
   endfunction

   function automatic bit payload_valid(logic [7:0] t);
      logic [7:0]  ids;
      logic [31:0] lease;
      ids = 8'h00;
      case (t)
         T_HELLO:
            return !(st(32) > st(33) || st(34) != 0 || st(35) != 0 ||
                     st(32) > 1 || st(33) < 1);
         T_SETCFG:   return st(78) == 8'd10;
         T_CAPTURE:  return !(st(69) != 0 || st(70) != 0 || st(71) != 0 || st(68) > 2);
         T_LOOPBACK: return !(st(68) != 8 || st(69) != 0 || st(70) != 0 || st(71) != 0);
         T_PERIODIC: begin
            for (int i = 32; i < 48; i++) ids |= st(i);
            lease = st32(92);
            return !(ids == 0 || st32(84) < MIN_INTERVAL ||
                     lease < LEASE_MIN || lease > LEASE_MAX);
         end
         T_RENEW: begin
            lease = st32(52);
            return !(st32(48) == 0 || lease < LEASE_MIN || lease > LEASE_MAX);
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic void rx_restart();
      rx_count     = 0;
      rx_frame_len = 0;
      rx_crc       = CRC_ONES;
   endfunction

   function automatic void expect_status(status_type s);
      rsp_type r;
      r        = '0;
      r.status = s;
      r.last   = 1'b1;
      expected_q.push_back(r);
   endfunction

   function automatic void predict_word(logic f, logic [7:0] b);
      int unsigned idx, len, words, p;
      logic [15:0] fl;
      logic [63:0] wd;
      logic [7:0]  t;
      logic [7:0]  flags;
      rsp_type     r;
      if (f == FUNC_TIMEOUT) begin
         rx_restart();
         expect_status(ST_TIMEOUT);
         return;
      end
      // a byte that breaks the sync word restarts the hunt, 0x55 counts as first
      if (rx_count < 4 && b != sync_seq[rx_count]) begin
         rx_restart();
         if (b == SYNC0) begin
            rx_store[0] = b;
            rx_count    = 1;
         end
         expect_status(ST_INCOMPLETE);
         return;
      end
      if (rx_count >= BUFFER_BYTES) begin
         rx_restart();
         expect_status(ST_BAD_LENGTH);
         return;
      end
      idx           = rx_count;
      rx_store[idx] = b;
      rx_count      = idx + 1;
      if (idx >= 4 && (idx < HDR_BYTES || idx + CRC_BYTES < rx_frame_len))
         rx_crc = crc_update(rx_crc, b);
      if (rx_count == HDR_BYTES) begin
         fl  = {st(7), st(6)};
         len = st32(12);
         if (st(4) != 8'd1 || (fl & ~FLAG_MASK) != 0) begin
            rx_restart();
            expect_status(ST_BAD_HEADER);
            return;
         end
         if (len > MAX_PAYLOAD ||
             (known_length(st(5)) >= 0 && known_length(st(5)) != len)) begin
            rx_restart();
            expect_status(ST_BAD_LENGTH);
            return;
         end
         rx_frame_len = HDR_BYTES + len + CRC_BYTES;
      end
      if (rx_frame_len == 0 || rx_count < rx_frame_len) begin
         expect_status(ST_INCOMPLETE);
         return;
      end
      len = rx_frame_len - HDR_BYTES - CRC_BYTES;
      if (st32(HDR_BYTES + len) != ~rx_crc) begin
         rx_restart();
         expect_status(ST_BAD_CRC);
         return;
      end
      t = st(5);
      if (!payload_valid(t)) begin
         rx_restart();
         expect_status(ST_BAD_PAYLOAD);
         return;
      end
      flags = st(6);
      words = (len + 7) / 8;
      if (words == 0) words = 1;
      for (int unsigned w = 0; w < words; w++) begin
         wd = '0;
         for (int k = 0; k < 8; k++) begin
            p = w * 8 + k;
            if (p < len) wd[8*k +: 8] = st(HDR_BYTES + p);
         end
         r.status          = ST_FRAME;
         r.msg_type        = t;
         r.frame_flags     = flags[2:0];
         r.sequence_number = st32(8);
         r.payload_bytes   = len[8:0];
         r.word_index      = w[4:0];
         r.payload_word    = wd;
         r.last            = (w + 1 == words);
         expected_q.push_back(r);
      end
      rx_restart();
   endfunction

   function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
         $error("%s: expected %h, got %h", name, e, a);
         errors++;
      end
   endfunction

   task automatic send_word(logic f, logic [7:0] b);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.func      <= f;
      req_if.data_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_word(f, b);
      items_sent++;
   endtask

   task automatic send_frame();
      logic [7:0]  pay [256];
      logic [7:0]  fb [$];
      logic [7:0]  t;
      logic [31:0] c, v, lf;
      int          n, kind, cut, r;
      r = $urandom_range(0, 15);
      case (r)
         0: t = T_HELLO;
         1: t = T_GETCAP;
         2: t = T_GETCFG;
         3: t = T_SETCFG;
         4: t = T_CAPTURE;
         5: t = T_PERIODIC;
         6: t = T_STOP;
         7: t = T_STATUS;
         8: t = T_RENEW;
         9: t = T_LOOPBACK;
         default: t = 8'($urandom_range(0, 255));
      endcase
      n = known_length(t);
      if (n < 0) n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, MAX_PAYLOAD)
                                                 : $urandom_range(0, 24);
      foreach (pay[i]) pay[i] = 8'($urandom_range(0, 255));
      kind = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 7);
      // kind: 1 version, 2 flags, 3 length, 4 crc, 5 payload, 6 timeout, 7 truncate
      v = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? LEASE_MIN : LEASE_MAX)
                                      : $urandom_range(LEASE_MIN, LEASE_MAX);
      if (kind != 5) begin
         case (t)
            T_HELLO: begin
               pay[16] = 8'($urandom_range(0, 1));
               pay[17] = 8'($urandom_range(1, 255));
               pay[18] = 8'h00;
               pay[19] = 8'h00;
            end
            T_SETCFG: pay[62] = 8'd10;
            T_CAPTURE: begin
               pay[52] = 8'($urandom_range(0, 2));
               pay[53] = 8'h00; pay[54] = 8'h00; pay[55] = 8'h00;
            end
            T_LOOPBACK: begin
               pay[52] = 8'd8;
               pay[53] = 8'h00; pay[54] = 8'h00; pay[55] = 8'h00;
            end
            T_PERIODIC: begin
               pay[16 + $urandom_range(0, 15)] = 8'($urandom_range(1, 255));
               pay[71] = 8'($urandom_range(1, 255));
               {pay[79], pay[78], pay[77], pay[76]} = v;
            end
            T_RENEW: begin
               pay[35] = 8'($urandom_range(1, 255));
               {pay[39], pay[38], pay[37], pay[36]} = v;
            end
            default: ;
         endcase
      end
      fb.push_back(SYNC0); fb.push_back(SYNC1); fb.push_back(SYNC2); fb.push_back(SYNC3);
      fb.push_back((kind == 1) ? 8'($urandom_range(2, 255)) : 8'd1);
      fb.push_back(t);
      fb.push_back(8'($urandom_range(0, (kind == 2) ? 255 : 7)));
      fb.push_back((kind == 2) ? 8'($urandom_range(1, 255)) : 8'h00);
      for (int i = 0; i < 4; i++) fb.push_back(8'($urandom_range(0, 255)));
      lf = n;
      if (kind == 3) lf = $urandom_range(0, 1) ? n + 1 : $urandom_range(MAX_PAYLOAD + 1, 32'hFFFFFFFF);
      for (int i = 0; i < 4; i++) fb.push_back(lf[8*i +: 8]);
      if (kind < 1 || kind > 3) begin
         for (int i = 0; i < n; i++) fb.push_back(pay[i]);
         c = CRC_ONES;
         for (int i = 4; i < fb.size(); i++) c = crc_update(c, fb[i]);
         c = ~c;
         if (kind == 4) c[$urandom_range(0, 31)] ^= 1'b1;
         for (int i = 0; i < 4; i++) fb.push_back(c[8*i +: 8]);
      end
      cut = (kind >= 6) ? $urandom_range(4, fb.size() - 1) : fb.size();
      for (int i = 0; i < cut; i++) send_word(1'b0, fb[i]);
      if (kind == 6) send_word(FUNC_TIMEOUT, 8'($urandom_range(0, 255)));
   endtask

   // receiver side: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left     <= hold_left - 1;
         rsp_if.ready  <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served   <= hold_served + 1;
         hold_left     <= HOLD_CYCLES;
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready  <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected result word: status %0d", rsp_if.status);
            errors++;
         end else begin
            e = expected_q.pop_front();
            check_field("status", e.status, rsp_if.status);
            check_field("msg_type", e.msg_type, rsp_if.msg_type);
            check_field("frame_flags", e.frame_flags, rsp_if.frame_flags);
            check_field("sequence_number", e.sequence_number, rsp_if.sequence_number);
            check_field("payload_bytes", e.payload_bytes, rsp_if.payload_bytes);
            check_field("word_index", e.word_index, rsp_if.word_index);
            check_field("payload_word", e.payload_word, rsp_if.payload_word);
            check_field("last", e.last, rsp_if.last);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int  ph;
      bit  held;
      held = 1'b0;
      req_if.valid     <= 1'b0;
      req_if.func      <= 1'b0;
      req_if.data_byte <= 8'h00;
      foreach (rx_store[i]) rx_store[i] = 8'h00;
      rx_restart();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].f, dir_rows[i].b);
         if (dir_rows[i].typed) begin
            void'(expected_q.pop_back());
            expect_status(dir_rows[i].s);
         end
      end

      while (items_sent < ITEMS) begin
         ph        = (items_sent * 5) / ITEMS;
         idle_pct  = (ph == 1) ? 52 : (ph == 3) ? 32 : 0;
         stall_pct = (ph == 2) ? 52 : (ph == 3) ? 32 : 0;
         if (!held && items_sent >= ITEMS * 3 / 10) begin
            hold_asked++;
            held = 1'b1;
         end
         case ($urandom_range(0, 99)) inside
            [0:7]: repeat ($urandom_range(1, 6))
               send_word(1'b0, $urandom_range(0, 3) == 0 ? SYNC0 : 8'($urandom_range(0, 255)));
            [8:11]: send_word(FUNC_TIMEOUT, 8'($urandom_range(0, 255)));
            default: send_frame();
         endcase
      end
      req_if.valid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
